### hdl/matrix_add_sub_multiply_core_macros.svh
// Assertion helpers for the matrix core.
`ifndef MATRIX_ADD_SUB_MULTIPLY_CORE_MACROS_SVH
`define MATRIX_ADD_SUB_MULTIPLY_CORE_MACROS_SVH

`ifndef SYNTH
`define MAS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("matrix core assertion failed");
`define MAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("matrix core assertion failed");
`else
`define MAS_ASSERT_IMPL(label, ante, cons)
`define MAS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hdl/mas_pkg.sv
`timescale 1ns / 1ps
package mas_pkg;

  localparam int MAX_DIM = 8;
  localparam int ELEMENT_WIDTH = 16;
  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int DIM_W = 4;
  localparam int SUM_W = 17;
  localparam int PROD_W = 2 * ELEMENT_WIDTH;
  localparam int ACC_W = 35;

  localparam logic [1:0] KIND_WR_A = 2'd0;
  localparam logic [1:0] KIND_WR_B = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [1:0] REG_ROWS_A = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B = 2'd2;

  typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows_a;
    logic [DIM_W-1:0] inner_dim;
    logic [DIM_W-1:0] cols_b;
  } cfg_t;

  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    elem_t wr_data;
    logic  rd_en;
    addr_t rd_addr;
  } bank_req_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] lim;
    lim = DIM_W'(MAX_DIM);
    return (v > lim) ? lim : v;
  endfunction

endpackage

### hdl/mas_bank.sv
`timescale 1ns / 1ps
module mas_bank (
  input  logic              clk,
  input  logic              rst,
  input  mas_pkg::bank_req_t req,
  output mas_pkg::elem_t    rd_data
);
  import mas_pkg::*;

  elem_t            mem [DEPTH];
  logic [DEPTH-1:0] valid;

  // entries not yet written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= valid[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

endmodule

### hdl/mas_ctrl.sv
`timescale 1ns / 1ps
`include "matrix_add_sub_multiply_core_macros.svh"
module mas_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              kind,
  input  logic [2:0]              row,
  input  logic [2:0]              col,
  input  logic signed [15:0]      value,
  input  mas_pkg::cfg_t           cfg,
  output mas_pkg::bank_req_t      req_a,
  output mas_pkg::bank_req_t      req_b,
  input  mas_pkg::elem_t          a_data,
  input  mas_pkg::elem_t          b_data,
  output logic                    done,
  output logic [2:0]              out_row,
  output logic [2:0]              out_col,
  output logic signed [16:0]      sum,
  output logic signed [16:0]      difference,
  output logic signed [34:0]      product,
  output logic                    sum_valid,
  output logic                    product_valid
);
  import mas_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM = 2'd1;
  localparam logic [1:0] ST_RUN = 2'd2;

  logic [1:0]               state;
  logic [IDX_W-1:0]         r_q;
  logic [IDX_W-1:0]         c_q;
  logic [DIM_W-1:0]         n_q;
  logic [DIM_W-1:0]         iss;
  logic                     sv_q;
  logic                     pv_q;
  logic                     rd_v;
  logic                     mul_v;
  logic signed [PROD_W-1:0] mul_q;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [SUM_W-1:0]  diff_q;

  logic             accept;
  logic             query;
  logic             issue;
  logic             finish;
  logic [DIM_W-1:0] m_dim;
  logic [DIM_W-1:0] n_dim;
  logic [DIM_W-1:0] k_dim;
  logic             sv;
  logic             pv;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign query  = accept && (kind == KIND_QUERY);
  assign m_dim  = clamp_dim(cfg.rows_a);
  assign n_dim  = clamp_dim(cfg.inner_dim);
  assign k_dim  = clamp_dim(cfg.cols_b);
  assign sv     = ({1'b0, row} < m_dim) && ({1'b0, col} < n_dim);
  assign pv     = ({1'b0, row} < m_dim) && ({1'b0, col} < k_dim);
  assign issue  = ((state == ST_SUM) || (state == ST_RUN)) && (iss < n_q);
  assign finish = (state == ST_RUN) && !issue && !rd_v && !mul_v;

  always_comb begin
    req_a.wr_en   = accept && (kind == KIND_WR_A);
    req_a.wr_addr = {row, col};
    req_a.wr_data = value[ELEMENT_WIDTH-1:0];
    req_b.wr_en   = accept && (kind == KIND_WR_B);
    req_b.wr_addr = {row, col};
    req_b.wr_data = value[ELEMENT_WIDTH-1:0];
    if (state == ST_IDLE) begin
      req_a.rd_en   = query;
      req_a.rd_addr = {row, col};
      req_b.rd_en   = query;
      req_b.rd_addr = {row, col};
    end else begin
      req_a.rd_en   = issue;
      req_a.rd_addr = {r_q, iss[IDX_W-1:0]};
      req_b.rd_en   = issue;
      req_b.rd_addr = {iss[IDX_W-1:0], c_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      iss   <= '0;
      n_q   <= '0;
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (query) begin
            r_q   <= row;
            c_q   <= col;
            n_q   <= n_dim;
            sv_q  <= sv;
            pv_q  <= pv;
            iss   <= '0;
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          sum_q  <= sv_q ? (SUM_W'(a_data) + SUM_W'(b_data)) : '0;
          diff_q <= sv_q ? (SUM_W'(a_data) - SUM_W'(b_data)) : '0;
          acc    <= '0;
          if (issue) begin
            iss <= iss + 1'b1;
          end
          rd_v  <= issue;
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (issue) begin
            iss <= iss + 1'b1;
          end
          rd_v  <= issue;
          mul_v <= rd_v;
          if (rd_v) begin
            mul_q <= PROD_W'(a_data) * PROD_W'(b_data);
          end
          if (mul_v) begin
            acc <= acc + ACC_W'(mul_q);
          end
          if (finish) begin
            state         <= ST_IDLE;
            done          <= 1'b1;
            out_row       <= r_q;
            out_col       <= c_q;
            sum           <= sum_q;
            difference    <= diff_q;
            product       <= pv_q ? acc : '0;
            sum_valid     <= sv_q;
            product_valid <= pv_q;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `MAS_ASSERT_IMPL(a_done_idle, done, state == ST_IDLE)
  `MAS_ASSERT_NEXT(a_query_starts, query, state == ST_SUM)
  `MAS_ASSERT_IMPL(a_mul_in_run, mul_v, state == ST_RUN)
  `MAS_ASSERT_IMPL(a_iss_bound, 1'b1, iss <= n_q)

endmodule

### hdl/matrix_add_sub_multiply_core.sv
`timescale 1ns / 1ps
// Writes take effect at the accept edge; a query strobes done for one cycle when its
// result is ready, with n = clamped inner_dim (0..8) products summed into product.
// Writes are taken one per cycle while busy is low; a query holds busy until its done
// strobe, and no new transaction is accepted before then.
// Reset (rst, synchronous): both matrices read as zero, registers return to 1.
// Results are strobed for one cycle on done; the receiver cannot stall.
module matrix_add_sub_multiply_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [2:0]         row,
  input  logic [2:0]         col,
  input  logic signed [15:0] value,
  output logic               done,
  output logic [2:0]         out_row,
  output logic [2:0]         out_col,
  output logic signed [16:0] sum,
  output logic signed [16:0] difference,
  output logic signed [34:0] product,
  output logic               sum_valid,
  output logic               product_valid,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import mas_pkg::*;

  cfg_t      cfg;
  bank_req_t req_a;
  bank_req_t req_b;
  elem_t     a_data;
  elem_t     b_data;
  logic      cfg_wr;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows_a    <= DIM_W'(1);
      cfg.inner_dim <= DIM_W'(1);
      cfg.cols_b    <= DIM_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ROWS_A:    cfg.rows_a    <= pwdata[DIM_W-1:0];
        REG_INNER_DIM: cfg.inner_dim <= pwdata[DIM_W-1:0];
        REG_COLS_B:    cfg.cols_b    <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROWS_A:    prdata = {{(32-DIM_W){1'b0}}, cfg.rows_a};
      REG_INNER_DIM: prdata = {{(32-DIM_W){1'b0}}, cfg.inner_dim};
      REG_COLS_B:    prdata = {{(32-DIM_W){1'b0}}, cfg.cols_b};
      default:       prdata = '0;
    endcase
  end

  mas_bank u_bank_a (
    .clk     (clk),
    .rst     (rst),
    .req     (req_a),
    .rd_data (a_data)
  );

  mas_bank u_bank_b (
    .clk     (clk),
    .rst     (rst),
    .req     (req_b),
    .rd_data (b_data)
  );

  mas_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .row           (row),
    .col           (col),
    .value         (value),
    .cfg           (cfg),
    .req_a         (req_a),
    .req_b         (req_b),
    .a_data        (a_data),
    .b_data        (b_data),
    .done          (done),
    .out_row       (out_row),
    .out_col       (out_col),
    .sum           (sum),
    .difference    (difference),
    .product       (product),
    .sum_valid     (sum_valid),
    .product_valid (product_valid)
  );

endmodule
